### sv/fwt_pkg.sv
// ----------------------------------------------------------------------------
// fwt_pkg
// Shared sizes, command codes and controller/datapath interface types for
// the binary indexed tree block.
// ----------------------------------------------------------------------------
package fwt_pkg;

   // tree geometry
   localparam int TREE_SIZE = 4096;
   localparam int ADDR_W    = $clog2(TREE_SIZE);
   localparam int POS_W     = 13;
   localparam int DATA_W    = 32;
   // node index must hold TREE_SIZE plus one lowbit step past it
   localparam int IDX_W     = (ADDR_W + 2 > POS_W) ? ADDR_W + 2 : POS_W;

   // command codes on req_cmd
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_QRY_RD,
      ST_QRY_FIN,
      ST_QRY_RSP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request fields
      logic acc_clr;  // clear query accumulator
      logic clr_wr;   // write zero at clear pointer, advance pointer
      logic mem_rd;   // read node idx-1
      logic rd_acc;   // read data goes into the accumulator
      logic mem_wr;   // write read data + delta at node idx-1
      logic idx_up;   // idx += lowbit(idx)
      logic idx_dn;   // idx -= lowbit(idx)
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last; // clear pointer at last entry
      logic idx_ok;   // 1 <= idx <= TREE_SIZE
      logic idx_zero; // idx == 0
   } dp_status_type;

endpackage

### sv/fenwick_tree_update_prefix_sum.sv
// ----------------------------------------------------------------------------
// fenwick_tree_update_prefix_sum
// Binary indexed tree of 32-bit counters: update adds a delta along the
// lowbit chain, query returns the wrapped prefix sum.
// ----------------------------------------------------------------------------
// Update: read then write per node on the chain, through the single-port
//   node memory of 4096 entries.
// Query: one node read per set bit of the index, one node read per cycle;
//   the result strobe comes in the last busy cycle.
// Reset: busy stays high for a clearing pass over all TREE_SIZE (4096) entries
//   that zeroes the node memory. Results are never stalled by the receiver.
module fenwick_tree_update_prefix_sum
   import fwt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_cmd,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_delta,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_prefix_sum
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_cmd),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   fwt_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_delta    (req_delta),
      .status       (status),
      .prefix_sum   (rsp_prefix_sum)
   );

   // a result beat lasts exactly one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // an accepted command keeps the block busy in the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a command");

   // the clearing pass blocks commands right after reset
   a_reset_busy: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> busy)
      else $error("block accepts commands during clearing pass");

   // results only come out of a command in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

endmodule

### sv/fwt_ctrl.sv
// ----------------------------------------------------------------------------
// fwt_ctrl
// Sequencer for the tree walk: memory clearing pass after reset, update
// read-modify-write per node, and query read/accumulate per node.
// ----------------------------------------------------------------------------
module fwt_ctrl
   import fwt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_cmd,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = (req_cmd == CMD_UPDATE) ? ST_UPD_RD : ST_QRY_RD;
         end
         ST_UPD_RD: begin
            state_in = status.idx_ok ? ST_UPD_WR : ST_IDLE;
         end
         ST_UPD_WR: begin
            state_in = ST_UPD_RD;
         end
         ST_QRY_RD: begin
            if (status.idx_zero) state_in = ST_QRY_FIN;
         end
         ST_QRY_FIN: begin
            state_in = ST_QRY_RSP;
         end
         ST_QRY_RSP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      rsp_strobe = 1'b0;
      busy       = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
         end
         ST_IDLE: begin
            cmd.load    = start;
            cmd.acc_clr = start;
         end
         ST_UPD_RD: begin
            cmd.mem_rd = status.idx_ok;
         end
         ST_UPD_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.idx_up = 1'b1;
         end
         ST_QRY_RD: begin
            cmd.mem_rd = !status.idx_zero;
            cmd.rd_acc = !status.idx_zero;
            cmd.idx_dn = !status.idx_zero;
         end
         ST_QRY_FIN: begin
            // no command; the accumulator already holds the last read data
         end
         ST_QRY_RSP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### sv/fwt_datapath.sv
// ----------------------------------------------------------------------------
// fwt_datapath
// Node memory (single port, registered read), node index walker,
// update adder and query accumulator.
// ----------------------------------------------------------------------------
module fwt_datapath
   import fwt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   input  logic                     req_cmd,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_delta,
   output dp_status_type            status,
   output logic signed [DATA_W-1:0] prefix_sum
);

   localparam logic [IDX_W-1:0]  TREE_SIZE_IDX = IDX_W'(TREE_SIZE);
   localparam logic [ADDR_W-1:0] CLR_LAST      = ADDR_W'(TREE_SIZE - 1);

   logic [DATA_W-1:0] mem [TREE_SIZE];

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DATA_W-1:0] delta_ff;
   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              acc_tag_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   logic [IDX_W-1:0]  pos_ext;
   logic [IDX_W-1:0]  low_bit;
   logic [IDX_W-1:0]  idx_m1;
   logic [ADDR_W-1:0] mem_addr;
   logic [DATA_W-1:0] mem_wdata;
   logic              mem_we;

   // request capture with query saturation, then lowbit walk
   assign pos_ext = IDX_W'(req_position);
   assign low_bit = idx_ff & (~idx_ff + IDX_W'(1));

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         if (req_cmd == CMD_QUERY && pos_ext > TREE_SIZE_IDX) begin
            idx_in = TREE_SIZE_IDX;
         end else begin
            idx_in = pos_ext;
         end
      end else if (cmd.idx_up) begin
         idx_in = idx_ff + low_bit;
      end else if (cmd.idx_dn) begin
         idx_in = idx_ff - low_bit;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) delta_ff <= req_delta;
   end

   // status back to the controller
   assign status.idx_zero = (idx_ff == '0);
   assign status.idx_ok   = (idx_ff != '0) && (idx_ff <= TREE_SIZE_IDX);
   assign status.clr_last = (clr_cnt_ff == CLR_LAST);

   // clearing pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr && !status.clr_last) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
      end
   end

   // single memory port
   assign idx_m1    = idx_ff - IDX_W'(1);
   assign mem_addr  = cmd.clr_wr ? clr_cnt_ff : idx_m1[ADDR_W-1:0];
   assign mem_we    = cmd.clr_wr || cmd.mem_wr;
   assign mem_wdata = cmd.clr_wr ? '0 : rd_data_ff + delta_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // query accumulator: adds read data in the cycle after each query read
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_tag_ff <= 1'b0;
      end else begin
         acc_tag_ff <= cmd.mem_rd && cmd.rd_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (acc_tag_ff) begin
         acc_ff <= acc_ff + rd_data_ff;
      end
   end

   assign prefix_sum = acc_ff;

endmodule
